// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the response decoder.
// Has no dependencies. SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define CHK_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define CHK_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_IMPL(name, clk, rst, ante, cons)
`define CHK_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/mrrd_pkg.sv -----
// Types, constants and the CRC step for the Modbus read response decoder.
// Has no dependencies; every module of the block imports it.
package mrrd_pkg;

   // Frame layout.
   localparam int REGISTER_FIELDS = 5;
   localparam int HEADER_BYTES    = 3;
   localparam int CHECK_BYTES     = 2;
   localparam int MIN_LEN         = HEADER_BYTES + CHECK_BYTES;
   localparam int CAPTURE_END     = HEADER_BYTES + 2 * REGISTER_FIELDS;
   localparam int MAX_TYPE        = 5;

   // Register lanes inside the captured block.
   localparam int REG_GAS    = 0;
   localparam int REG_STATUS = 1;
   localparam int REG_DEC    = 2;
   localparam int REG_UNIT   = 3;
   localparam int REG_TYPE   = 4;

   // Byte counter saturates at its all-ones value.
   localparam int CNT_W = 9;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  SLAVE_RESET       = 8'h01;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;

   // Decimal point codes and the matching scale factors to hundredths.
   localparam logic [15:0] DEC_ONE    = 16'd1;
   localparam logic [15:0] DEC_TWO    = 16'd2;
   localparam int          SCALE_W    = 7;
   localparam logic [SCALE_W-1:0] SCALE_INT = 7'd100;
   localparam logic [SCALE_W-1:0] SCALE_ONE = 7'd10;
   localparam logic [SCALE_W-1:0] SCALE_TWO = 7'd1;

   // Status word bits.
   localparam int ST_FAULT = 0;
   localparam int ST_LOW   = 1;
   localparam int ST_HIGH  = 2;

   // Error codes, in order of check priority.
   localparam logic [3:0] ERR_OK       = 4'd0;
   localparam logic [3:0] ERR_SHORT    = 4'd1;
   localparam logic [3:0] ERR_SLAVE    = 4'd2;
   localparam logic [3:0] ERR_FUNCTION = 4'd3;
   localparam logic [3:0] ERR_CRC      = 4'd4;
   localparam logic [3:0] ERR_LENGTH   = 4'd5;
   localparam logic [3:0] ERR_ODD      = 4'd6;
   localparam logic [3:0] ERR_FEW_REGS = 4'd7;
   localparam logic [3:0] ERR_TYPE     = 4'd8;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [3:0]  error_code;
      logic [15:0] gas_raw;
      logic [15:0] status_word;
      logic [15:0] point_code;
      logic [15:0] unit_sel;
      logic [2:0]  gas_kind;
      logic [22:0] value_hundredths;
      logic        fault_flag;
      logic        alarm_lo;
      logic        alarm_hi;
      logic        alarm_or;
   } rsp_type;

   // Everything the back end needs about one finished frame.
   typedef struct packed {
      logic [CNT_W-1:0]                 length;
      logic [7:0]                       slave;
      logic [7:0]                       func;
      logic [7:0]                       count;
      logic [15:0]                      crc_rx;
      logic [15:0]                      crc_run;
      logic [REGISTER_FIELDS-1:0][15:0] regs;
   } frame_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } qstat_type;

   // One byte through the reflected CRC-16/MODBUS.
   function automatic logic [15:0] mrrd_crc_byte(input logic [15:0] crc,
                                                 input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- hdl/mrrd_queue.sv -----
// Two-entry queue of finished frame summaries between front and back.
// Depends on mrrd_pkg.
module mrrd_queue import mrrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   input  logic      pop,
   output frame_type head_data,
   output qstat_type stat
);

   frame_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data      = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (cnt_ff != '0);
   assign stat.full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

endmodule

// ----- hdl/mrrd_front.sv -----
// Front end: takes frame bytes, runs the lagging CRC and captures header and registers.
// Depends on mrrd_pkg; hands one frame summary per frame to the queue.
module mrrd_front import mrrd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  req_type   req_data,
   input  logic      req_stall,
   output logic      push,
   output frame_type push_data
);

   logic [CNT_W-1:0]                 cnt_ff, cnt_in, cnt_upd;
   logic [15:0]                      crc_ff, crc_in, crc_upd;
   logic [15:0]                      trail_ff, trail_in, trail_upd;
   logic [7:0]                       slave_ff, slave_in, slave_upd;
   logic [7:0]                       func_ff, func_in, func_upd;
   logic [7:0]                       count_ff, count_in, count_upd;
   logic [REGISTER_FIELDS-1:0][15:0] regs_ff, regs_in, regs_upd;
   logic [3:0]                       offset;
   logic                             accepted;

   assign accepted = req_valid & ~req_stall;
   assign offset   = cnt_ff[3:0] - 4'(HEADER_BYTES);

   // Effect of the current byte on the frame state.
   always_comb begin
      // The CRC absorbs the byte that falls out of the two-byte trailing window.
      crc_upd   = (cnt_ff >= CNT_W'(CHECK_BYTES)) ? mrrd_crc_byte(crc_ff, trail_ff[15:8])
                                                  : crc_ff;
      trail_upd = {trail_ff[7:0], req_data.rx_byte};
      cnt_upd   = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
      slave_upd = slave_ff;
      func_upd  = func_ff;
      count_upd = count_ff;
      regs_upd  = regs_ff;
      if (cnt_ff == CNT_W'(0)) begin
         slave_upd = req_data.rx_byte;
      end
      if (cnt_ff == CNT_W'(1)) begin
         func_upd = req_data.rx_byte;
      end
      if (cnt_ff == CNT_W'(2)) begin
         count_upd = req_data.rx_byte;
      end
      // Big-endian register capture: high byte first, then the low byte.
      if (cnt_ff >= CNT_W'(HEADER_BYTES) && cnt_ff < CNT_W'(CAPTURE_END)) begin
         for (int i = 0; i < REGISTER_FIELDS; i++) begin
            if (offset[3:1] == 3'(i)) begin
               if (!offset[0]) begin
                  regs_upd[i] = {req_data.rx_byte, 8'h00};
               end else begin
                  regs_upd[i][7:0] = req_data.rx_byte;
               end
            end
         end
      end
   end

   // Next state: keep, advance, or clear after the last byte of a frame.
   always_comb begin
      cnt_in   = cnt_ff;
      crc_in   = crc_ff;
      trail_in = trail_ff;
      slave_in = slave_ff;
      func_in  = func_ff;
      count_in = count_ff;
      regs_in  = regs_ff;
      if (accepted) begin
         if (req_data.frame_end) begin
            cnt_in   = '0;
            crc_in   = CRC_INIT;
            trail_in = '0;
            slave_in = '0;
            func_in  = '0;
            count_in = '0;
            regs_in  = '0;
         end else begin
            cnt_in   = cnt_upd;
            crc_in   = crc_upd;
            trail_in = trail_upd;
            slave_in = slave_upd;
            func_in  = func_upd;
            count_in = count_upd;
            regs_in  = regs_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         crc_ff   <= CRC_INIT;
         trail_ff <= '0;
         slave_ff <= '0;
         func_ff  <= '0;
         count_ff <= '0;
         regs_ff  <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         trail_ff <= trail_in;
         slave_ff <= slave_in;
         func_ff  <= func_in;
         count_ff <= count_in;
         regs_ff  <= regs_in;
      end
   end

   // The summary of a finished frame goes to the queue with its last byte.
   assign push              = accepted & req_data.frame_end;
   assign push_data.length  = cnt_upd;
   assign push_data.slave   = slave_upd;
   assign push_data.func    = func_upd;
   assign push_data.count   = count_upd;
   assign push_data.crc_rx  = trail_upd;
   assign push_data.crc_run = crc_upd;
   assign push_data.regs    = regs_upd;

endmodule

// ----- hdl/mrrd_back.sv -----
// Back end: validates one frame summary, scales the reading, holds the result register.
// Depends on mrrd_pkg; pops summaries from the queue.
module mrrd_back import mrrd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] slave_address,
   input  qstat_type  qstat,
   input  frame_type  head_data,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [3:0]        err;
   logic [SCALE_W-1:0] scale;
   logic [22:0]       scaled;
   logic [15:0]       status;

   // Checks in priority order; the first failure wins.
   always_comb begin
      priority if (head_data.length < CNT_W'(MIN_LEN)) begin
         err = ERR_SHORT;
      end else if (head_data.slave != slave_address) begin
         err = ERR_SLAVE;
      end else if (head_data.func != FUNC_READ_HOLDING) begin
         err = ERR_FUNCTION;
      end else if (head_data.crc_rx != head_data.crc_run) begin
         err = ERR_CRC;
      end else if (10'(head_data.length) != 10'(MIN_LEN) + 10'(head_data.count)) begin
         err = ERR_LENGTH;
      end else if (head_data.count[0]) begin
         err = ERR_ODD;
      end else if (head_data.count[7:1] < 7'(REGISTER_FIELDS)) begin
         err = ERR_FEW_REGS;
      end else if (head_data.regs[REG_TYPE] > 16'(MAX_TYPE)) begin
         err = ERR_TYPE;
      end else begin
         err = ERR_OK;
      end
   end

   // Scale factor from the decimal point code; unknown codes read as integer.
   always_comb begin
      if (head_data.regs[REG_DEC] == DEC_ONE) begin
         scale = SCALE_ONE;
      end else if (head_data.regs[REG_DEC] == DEC_TWO) begin
         scale = SCALE_TWO;
      end else begin
         scale = SCALE_INT;
      end
   end

   // Both operands are widened first so the full product is kept.
   assign scaled = 23'(head_data.regs[REG_GAS]) * 23'(scale);
   assign status = head_data.regs[REG_STATUS];

   // Result fields; an error result carries only its code.
   always_comb begin
      rsp_data_in            = '0;
      rsp_data_in.error_code = err;
      if (err == ERR_OK) begin
         rsp_data_in.gas_raw          = head_data.regs[REG_GAS];
         rsp_data_in.status_word      = status;
         rsp_data_in.point_code       = head_data.regs[REG_DEC];
         rsp_data_in.unit_sel         = head_data.regs[REG_UNIT];
         rsp_data_in.gas_kind         = head_data.regs[REG_TYPE][2:0];
         rsp_data_in.value_hundredths = scaled;
         rsp_data_in.fault_flag       = status[ST_FAULT];
         rsp_data_in.alarm_lo         = status[ST_LOW];
         rsp_data_in.alarm_hi         = status[ST_HIGH];
         rsp_data_in.alarm_or         = status[ST_LOW] | status[ST_HIGH];
      end
   end

   // The result register takes a new summary whenever it is empty or being drained.
   assign pop = qstat.not_empty & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/modbus_read_response_decoder_top.sv -----
// Modbus function 03 response decoder. Bytes are taken one per clock cycle
// while a queue entry is free. The front end runs the CRC-16/MODBUS one byte
// per cycle while bytes are accepted and, on the byte flagged as frame end,
// writes a frame summary into a two-entry queue. The back end validates the
// summary and scales the reading with one small multiplier into the result
// register; a result is registered first in a queue entry, then in the result
// register. The input stalls only while both queue entries are occupied. The
// expected slave address (reset value 1) is written through the csr port,
// which is always ready.
// Depends on mrrd_pkg, mrrd_front, mrrd_queue, mrrd_back and assert_macros.svh.
`include "assert_macros.svh"

module modbus_read_response_decoder_top import mrrd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0] slave_address_ff, slave_address_in;
   logic       q_push;
   logic       q_pop;
   frame_type  q_push_data;
   frame_type  q_head;
   qstat_type  q_stat;
   logic       rsp_is_error;
   logic       rsp_is_blank;

   // Slave address register.
   assign csr_ready        = 1'b1;
   assign slave_address_in = (csr_valid & csr_ready) ? csr_data : slave_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_RESET;
      end else begin
         slave_address_ff <= slave_address_in;
      end
   end

   // Bytes wait only when no queue entry is free.
   assign req_stall = q_stat.full;

   mrrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .push      (q_push),
      .push_data (q_push_data)
   );

   mrrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .stat      (q_stat)
   );

   mrrd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .slave_address (slave_address_ff),
      .qstat         (q_stat),
      .head_data     (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   // Terms for the error result check.
   assign rsp_is_error = rsp_valid && (rsp_data.error_code != ERR_OK);
   assign rsp_is_blank = (rsp_data.gas_raw == '0) && (rsp_data.value_hundredths == '0);

   // A frame summary is never written into a full queue.
   `CHK_IMPL(a_no_overflow, clock, reset, q_push, !q_stat.full)
   // A finished frame is waiting in the queue on the next cycle.
   `CHK_NEXT(a_push_lands, clock, reset, q_push, q_stat.not_empty)
   // An error result carries no reading.
   `CHK_IMPL(a_err_clears, clock, reset, rsp_is_error, rsp_is_blank)

endmodule

// ----- sim/tb.sv -----
// Testbench for modbus_read_response_decoder_top: sends function 03 response frames one
// byte per transfer, predicts each decoded reading, and checks it against the result port.
// Depends on mrrd_pkg and the decoder RTL only.
module tb import mrrd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   typedef logic [7:0] frame_bytes_type[$];

   // How a random frame is built or damaged.
   typedef enum int {
      SHAPE_GOOD,
      SHAPE_BAD_SLAVE,
      SHAPE_BAD_FUNC,
      SHAPE_BIT_FLIP,
      SHAPE_CUT,
      SHAPE_FEW_BYTES,
      SHAPE_COUNT_OFF,
      SHAPE_NOISE
   } frame_shape_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data  = '0;

   // Decoder state as the testbench sees it.
   logic [7:0]       slave_cfg;
   logic [CNT_W-1:0] frame_len;
   logic [15:0]      crc_acc;
   logic [15:0]      tail;
   logic [7:0]       hdr_slave;
   logic [7:0]       hdr_func;
   logic [7:0]       hdr_count;
   logic [15:0]      regs[REGISTER_FIELDS];

   rsp_type pending_readings[$];

   bit idle_on = 1'b1;
   int bytes_sent;
   int frames_sent;
   int readings_checked;
   int mismatches;
   int cycles;
   int err_seen[16];

   modbus_read_response_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d readings pending", cycles,
                  pending_readings.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // The receiver stalls in random bursts while idling is enabled.
   always @(posedge clock) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 11)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Reflected CRC-16 step over one byte.
   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ 16'(d);
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic string reading_text(input rsp_type r);
      return $sformatf("err %0d gas %h st %h dec %h unit %h type %0d val %0d flags %b",
                       r.error_code, r.gas_raw, r.status_word, r.point_code, r.unit_sel,
                       r.gas_kind, r.value_hundredths,
                       {r.fault_flag, r.alarm_lo, r.alarm_hi, r.alarm_or});
   endfunction

   task automatic clear_frame_state();
      frame_len = '0;
      crc_acc   = CRC_INIT;
      tail      = '0;
      hdr_slave = '0;
      hdr_func  = '0;
      hdr_count = '0;
      foreach (regs[i]) regs[i] = '0;
   endtask

   // Advance the decoder state by one accepted byte; at frame end, queue the reading.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      rsp_type     r;
      int          pos;
      int          off;
      int          len;
      logic [22:0] scale;
      logic [3:0]  err;
      pos = int'(frame_len);
      // The CRC trails two bytes behind so the check bytes stay out of it.
      if (pos >= 2) crc_acc = crc_update(crc_acc, tail[15:8]);
      tail = {tail[7:0], b};
      if (pos == 0) begin
         hdr_slave = b;
      end else if (pos == 1) begin
         hdr_func = b;
      end else if (pos == 2) begin
         hdr_count = b;
      end else if (pos < CAPTURE_END) begin
         off = pos - HEADER_BYTES;
         if (off % 2 == 0) begin
            regs[off / 2] = {b, 8'h00};
         end else begin
            regs[off / 2][7:0] = b;
         end
      end
      if (frame_len != CNT_MAX) frame_len++;
      if (last) begin
         len = int'(frame_len);
         // First failing check decides the code.
         if (len < MIN_LEN) err = ERR_SHORT;
         else if (hdr_slave != slave_cfg) err = ERR_SLAVE;
         else if (hdr_func != FUNC_READ_HOLDING) err = ERR_FUNCTION;
         else if (tail != crc_acc) err = ERR_CRC;
         else if (len != MIN_LEN + int'(hdr_count)) err = ERR_LENGTH;
         else if (hdr_count[0]) err = ERR_ODD;
         else if (int'(hdr_count) / 2 < REGISTER_FIELDS) err = ERR_FEW_REGS;
         else if (regs[REG_TYPE] > MAX_TYPE) err = ERR_TYPE;
         else err = ERR_OK;
         r = '0;
         r.error_code = err;
         if (err == ERR_OK) begin
            r.gas_raw     = regs[REG_GAS];
            r.status_word = regs[REG_STATUS];
            r.point_code  = regs[REG_DEC];
            r.unit_sel    = regs[REG_UNIT];
            r.gas_kind    = regs[REG_TYPE][2:0];
            if (regs[REG_DEC] == DEC_ONE) scale = 23'(SCALE_ONE);
            else if (regs[REG_DEC] == DEC_TWO) scale = 23'(SCALE_TWO);
            else scale = 23'(SCALE_INT);
            r.value_hundredths = 23'(regs[REG_GAS]) * scale;
            r.fault_flag = regs[REG_STATUS][ST_FAULT];
            r.alarm_lo   = regs[REG_STATUS][ST_LOW];
            r.alarm_hi   = regs[REG_STATUS][ST_HIGH];
            r.alarm_or   = regs[REG_STATUS][ST_LOW] | regs[REG_STATUS][ST_HIGH];
         end
         pending_readings.insert(pending_readings.size(), r);
         clear_frame_state();
      end
   endtask

   // Compare every accepted result with the oldest pending reading.
   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("tb: result with no frame pending: %s", reading_text(rsp_data));
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            err_seen[want.error_code]++;
            if (rsp_data.error_code !== want.error_code ||
                rsp_data.gas_raw !== want.gas_raw ||
                rsp_data.status_word !== want.status_word ||
                rsp_data.point_code !== want.point_code ||
                rsp_data.unit_sel !== want.unit_sel ||
                rsp_data.gas_kind !== want.gas_kind ||
                rsp_data.value_hundredths !== want.value_hundredths ||
                rsp_data.fault_flag !== want.fault_flag ||
                rsp_data.alarm_lo !== want.alarm_lo ||
                rsp_data.alarm_hi !== want.alarm_hi ||
                rsp_data.alarm_or !== want.alarm_or) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("tb: reading %0d expected %s", readings_checked, reading_text(want));
                  $display("tb: reading %0d actual   %s", readings_checked,
                           reading_text(rsp_data));
               end
            end
         end
      end
   end

   // One byte transfer, with an occasional idle burst before it.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: b, frame_end: last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      decode_byte(b, last);
   endtask

   task automatic send_frame(input frame_bytes_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
      frames_sent++;
   endtask

   function automatic frame_bytes_type random_bytes(input int n);
      frame_bytes_type d;
      repeat (n) d.insert(d.size(), 8'($urandom));
      return d;
   endfunction

   // The five captured registers, big-endian, followed by extra data bytes.
   function automatic frame_bytes_type reg_block(input logic [15:0] gas,
                                                 input logic [15:0] status,
                                                 input logic [15:0] dec,
                                                 input logic [15:0] unit,
                                                 input logic [15:0] gtype, input int extra);
      frame_bytes_type d;
      logic [15:0]     w[REGISTER_FIELDS];
      w = '{gas, status, dec, unit, gtype};
      foreach (w[i]) begin
         d.insert(d.size(), w[i][15:8]);
         d.insert(d.size(), w[i][7:0]);
      end
      repeat (extra) d.insert(d.size(), 8'($urandom));
      return d;
   endfunction

   // Header, payload and check bytes; count_adj skews the byte count field.
   function automatic frame_bytes_type build_frame(input logic [7:0] slave,
                                                   input logic [7:0] func,
                                                   input frame_bytes_type payload,
                                                   input int count_adj);
      frame_bytes_type f;
      logic [15:0]     crc;
      f = {slave, func, 8'(payload.size() + count_adj)};
      foreach (payload[i]) f.insert(f.size(), payload[i]);
      crc = CRC_INIT;
      foreach (f[i]) crc = crc_update(crc, f[i]);
      f.insert(f.size(), crc[15:8]);
      f.insert(f.size(), crc[7:0]);
      return f;
   endfunction

   // Let every pending reading arrive and the decoder settle.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_slave_address(input logic [7:0] addr);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_data  <= addr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      slave_cfg = addr;
   endtask

   // Mostly well-formed frames with random content; the rest damaged or pure noise.
   task automatic random_frame();
      frame_bytes_type payload;
      frame_bytes_type f;
      frame_shape_type shape;
      logic [15:0]     dec;
      logic [15:0]     gtype;
      int              r;
      int              adj;
      int              idx;
      r = $urandom_range(0, 15);
      shape = (r < 9) ? SHAPE_GOOD : frame_shape_type'(r - 8);
      case ($urandom_range(0, 3))
         0: dec = 16'd0;
         1: dec = DEC_ONE;
         2: dec = DEC_TWO;
         default: dec = 16'($urandom);
      endcase
      gtype = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, MAX_TYPE));
      payload = reg_block(16'($urandom), 16'($urandom), dec, 16'($urandom), gtype,
                          ($urandom_range(0, 4) == 0) ? 2 * $urandom_range(1, 6) : 0);
      if (shape == SHAPE_FEW_BYTES) payload = random_bytes($urandom_range(0, 9));
      adj = 0;
      if (shape == SHAPE_COUNT_OFF)
         adj = $urandom_range(0, 1) ? $urandom_range(1, 4) : -$urandom_range(1, 4);
      f = build_frame(slave_cfg, FUNC_READ_HOLDING, payload, adj);
      case (shape)
         SHAPE_BAD_SLAVE: f[0] ^= 8'($urandom_range(1, 255));
         SHAPE_BAD_FUNC:  f[1] ^= 8'($urandom_range(1, 255));
         SHAPE_BIT_FLIP: begin
            idx = $urandom_range(3, f.size() - 1);
            f[idx] ^= 8'(1 << $urandom_range(0, 7));
         end
         SHAPE_CUT:   repeat ($urandom_range(1, f.size() - 1)) void'(f.pop_back());
         SHAPE_NOISE: f = random_bytes($urandom_range(1, 24));
         default: ;
      endcase
      send_frame(f);
   endtask

   // Well-formed frames at the extremes of the registers and all scaling codes.
   task automatic test_decode_extremes();
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd5, 0), 0));
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'hFFFF, 16'h0001, DEC_ONE, 16'd0, 16'd0, 0), 0));
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'h1234, 16'h0002, DEC_TWO, 16'd3, 16'd1, 0), 0));
      // An undefined decimal code reads as an integer.
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'h0000, 16'h0004, 16'hFFFF, 16'h8000, 16'd2, 0), 0));
      // Registers past the fifth go into the CRC and length only.
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'h00FF, 16'h0006, 16'd3, 16'd1, 16'd4, 10), 0));
   endtask

   // At least one frame for each validation failure, in check order.
   task automatic test_error_checks();
      frame_bytes_type good;
      frame_bytes_type f;
      good = reg_block(16'd1234, 16'h0003, DEC_ONE, 16'd2, 16'd3, 0);
      // Too short to hold a header and a check.
      send_frame(random_bytes(1));
      send_frame(random_bytes(4));
      // Wrong slave, then an exception reply in place of function 03.
      send_frame(build_frame(8'h02, FUNC_READ_HOLDING, good, 0));
      send_frame(build_frame(SLAVE_RESET, 8'h83, good, 0));
      // Damaged check byte.
      f = build_frame(SLAVE_RESET, FUNC_READ_HOLDING, good, 0);
      f[f.size() - 1] ^= 8'h80;
      send_frame(f);
      // Byte count that disagrees with the frame length.
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING, good, 2));
      // Odd count, too few registers, and an empty register block.
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'd7, 16'd0, 16'd0, 16'd0, 16'd0, 1), 0));
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING, random_bytes(8), 0));
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING, random_bytes(0), 0));
      // Gas type just above its limit and at the top of the register.
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'd100, 16'd0, 16'd0, 16'd0, 16'd6, 0), 0));
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING,
                 reg_block(16'hFFFF, 16'd0, DEC_TWO, 16'd0, 16'hFFFF, 0), 0));
      // A clean frame right after shows the frame state was cleared.
      send_frame(build_frame(SLAVE_RESET, FUNC_READ_HOLDING, good, 0));
   endtask

   // The expected address at both extremes and one value in between.
   task automatic test_slave_address();
      logic [7:0] addrs[3];
      addrs = '{8'h00, 8'hFF, 8'($urandom_range(2, 254))};
      foreach (addrs[i]) begin
         write_slave_address(addrs[i]);
         send_frame(build_frame(addrs[i], FUNC_READ_HOLDING,
                    reg_block(16'($urandom), 16'($urandom), DEC_TWO, 16'd1, 16'd4, 0), 0));
         send_frame(build_frame(addrs[i] ^ 8'h01, FUNC_READ_HOLDING,
                    reg_block(16'd5, 16'd0, 16'd0, 16'd0, 16'd0, 0), 0));
         random_frame();
      end
   endtask

   // Random frames under random idling on both sides, with quiet stretches.
   task automatic test_random_traffic();
      int start_bytes;
      write_slave_address(8'($urandom));
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 100) begin
         idle_on = ($urandom_range(0, 4) != 0);
         random_frame();
      end
      idle_on = 1'b1;
   endtask

   // Frames back to back with no idling on either side.
   task automatic test_streaming_no_idle();
      int start_bytes;
      write_slave_address(SLAVE_RESET);
      idle_on = 1'b0;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 60) random_frame();
   endtask

   initial begin
      slave_cfg = SLAVE_RESET;
      clear_frame_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_decode_extremes();
      test_error_checks();
      test_slave_address();
      test_random_traffic();
      test_streaming_no_idle();
      wait_for_idle();
      $display("tb: %0d bytes in %0d frames, %0d readings checked, %0d mismatches",
               bytes_sent, frames_sent, readings_checked, mismatches);
      $display("tb: readings by error code 0-8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4],
               err_seen[5], err_seen[6], err_seen[7], err_seen[8]);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mrrd_pkg.sv
hdl/mrrd_queue.sv
hdl/mrrd_front.sv
hdl/mrrd_back.sv
hdl/modbus_read_response_decoder_top.sv
sim/tb.sv
